/* hw/rtl/stq_pkg.sv */
// Shared types and constants for the sorted timer event queue.
// Used by stq_cell and sorted_timer_event_queue_top; depends on nothing.
package stq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int FIRE_W      = $clog2(MAX_RESULTS);

    typedef enum logic [1:0] {
        KIND_ADD  = 2'd0,
        KIND_TICK = 2'd1,
        KIND_KILL = 2'd2,
        KIND_WIPE = 2'd3
    } kind_t;

    typedef struct packed {
        logic        [31:0] expiry;
        logic signed [15:0] table_id;
        logic        [15:0] owner_id;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD    = 2'd0,
        CELL_INSERT  = 2'd1,
        CELL_POP     = 2'd2,
        CELL_COMPACT = 2'd3
    } cell_op_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        cell_op_t    op;
        logic [31:0] add_expiry;
        logic [15:0] kill_owner;
        entry_t      new_entry;
    } cell_cmd_t;

    // Passed from each cell to the next one down the chain
    typedef struct packed {
        logic keep;  // this cell is occupied and expires before the new event
        logic gap;   // a matching owner sits at or before this cell
    } cell_link_t;

endpackage

/* hw/rtl/stq_cell.sv */
// One slot of the sorted queue: holds an event and moves it toward its neighbors.
// Depends on stq_pkg.
module stq_cell (
    input  logic               aclk,
    input  stq_pkg::cell_cmd_t cmd,
    input  logic               occupied,
    input  stq_pkg::cell_link_t link_in,
    input  stq_pkg::entry_t    prev_entry,
    input  stq_pkg::entry_t    next_entry,
    output stq_pkg::cell_link_t link_out,
    output stq_pkg::entry_t    entry
);
    import stq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb begin
        link_out.keep = occupied && (entry_reg.expiry < cmd.add_expiry);
        link_out.gap  = link_in.gap || (occupied && (entry_reg.owner_id == cmd.kill_owner));
        entry_next    = entry_reg;
        unique case (cmd.op)
            CELL_HOLD: begin
                entry_next = entry_reg;
            end
            CELL_INSERT: begin
                // equal expiry does not keep, so the newest event lands first
                if (!link_out.keep) begin
                    if (link_in.keep) begin
                        entry_next = cmd.new_entry;
                    end else begin
                        entry_next = prev_entry;
                    end
                end
            end
            CELL_POP: begin
                entry_next = next_entry;
            end
            CELL_COMPACT: begin
                // close the gap left by the first matching owner
                if (link_out.gap) begin
                    entry_next = next_entry;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

/* hw/rtl/sorted_timer_event_queue_top.sv */
// Sorted timer event queue: a chain of stq_cell slots kept in expiry order plus control.
// Depends on stq_pkg and stq_cell.
//
//   channel | direction | tdata                                         | tuser  | tlast
//   s_      | request   | now_time, delay, table_id, owner_id           | kind   | -
//   m_      | result    | fired_table, fired_owner, status, queued      | fired  | last
//
// Add and wipe are accepted from idle and answered in the next cycle. A tick is first
// loaded, then reports each fired event in turn (or one empty result). A kill is first
// loaded, then removes one matching event per pass down the cell chain, then gives
// its result. A new request is taken only when the controller is idle
// and the result register is free or being drained; m_tready low stalls firing.
// aresetn empties the queue; slot contents are not cleared.
module sorted_timer_event_queue_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // now_time[31:0], delay[63:32], table_id[79:64], owner_id[95:80]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // fired_table[15:0], fired_owner[31:16], status[32],
                                   // queued[37:33], zero[39:38]
    output logic        m_tuser,   // fired[0]
    output logic        m_tlast
);
    import stq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_KILL
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [FIRE_W-1:0]  fire_cnt_reg, fire_cnt_next;
    logic [31:0]        now_reg, now_next;
    logic [15:0]        owner_reg, owner_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [39:0]        m_tdata_reg, m_tdata_next;
    logic               m_tuser_reg, m_tuser_next;
    logic               m_tlast_reg, m_tlast_next;

    cell_cmd_t          cmd;
    entry_t             cell_entry [QUEUE_DEPTH];
    cell_link_t         link [QUEUE_DEPTH+1];

    logic [32:0]        exp_sum;
    logic [31:0]        in_now, in_delay, add_expiry;
    logic [15:0]        in_table, in_owner;
    logic               out_free, s_accept, head_due, next_due, fire_last;

    assign in_now   = s_tdata[31:0];
    assign in_delay = s_tdata[63:32];
    assign in_table = s_tdata[79:64];
    assign in_owner = s_tdata[95:80];

    // saturate the expiry at all ones
    assign exp_sum    = {1'b0, in_now} + {1'b0, in_delay};
    assign add_expiry = exp_sum[32] ? '1 : exp_sum[31:0];

    assign link[0] = '{keep: 1'b1, gap: 1'b0};

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            stq_cell u_cell (
                .aclk       (aclk),
                .cmd        (cmd),
                .occupied   (CNT_W'(gi) < count_reg),
                .link_in    (link[gi]),
                .prev_entry (cell_entry[(gi == 0) ? 0 : gi - 1]),
                .next_entry (cell_entry[(gi == QUEUE_DEPTH - 1) ? gi : gi + 1]),
                .link_out   (link[gi+1]),
                .entry      (cell_entry[gi])
            );
        end
    endgenerate

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign s_accept  = s_tvalid && s_tready;
    assign head_due  = (count_reg != '0) && (cell_entry[0].expiry <= now_reg);
    assign next_due  = (count_reg > CNT_W'(1)) && (cell_entry[1].expiry <= now_reg);
    assign fire_last = !next_due || (fire_cnt_reg == FIRE_W'(MAX_RESULTS - 1));

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        fire_cnt_next = fire_cnt_reg;
        now_next      = now_reg;
        owner_next    = owner_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;

        cmd.op                 = CELL_HOLD;
        cmd.add_expiry         = add_expiry;
        cmd.kill_owner         = owner_reg;
        cmd.new_entry.expiry   = add_expiry;
        cmd.new_entry.table_id = in_table;
        cmd.new_entry.owner_id = in_owner;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (kind_t'(s_tuser))
                        KIND_ADD: begin
                            m_tvalid_next = 1'b1;
                            m_tuser_next  = 1'b0;
                            m_tlast_next  = 1'b1;
                            if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                                m_tdata_next = {2'b00, 5'(count_reg), 1'b1, 32'd0};
                            end else begin
                                cmd.op       = CELL_INSERT;
                                count_next   = count_reg + 1'b1;
                                m_tdata_next = {2'b00, 5'(count_next), 1'b0, 32'd0};
                            end
                        end
                        KIND_TICK: begin
                            now_next      = in_now;
                            fire_cnt_next = '0;
                            state_next    = ST_TICK;
                        end
                        KIND_KILL: begin
                            owner_next = in_owner;
                            state_next = ST_KILL;
                        end
                        KIND_WIPE: begin
                            count_next    = '0;
                            m_tvalid_next = 1'b1;
                            m_tuser_next  = 1'b0;
                            m_tlast_next  = 1'b1;
                            m_tdata_next  = 40'd0;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_TICK: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    if (head_due) begin
                        // pop the head and report it
                        cmd.op        = CELL_POP;
                        count_next    = count_reg - 1'b1;
                        m_tuser_next  = 1'b1;
                        m_tlast_next  = fire_last;
                        m_tdata_next  = {2'b00, 5'(count_next), 1'b0,
                                         cell_entry[0].owner_id, cell_entry[0].table_id};
                        fire_cnt_next = fire_cnt_reg + 1'b1;
                        if (fire_last) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        m_tuser_next = 1'b0;
                        m_tlast_next = 1'b1;
                        m_tdata_next = {2'b00, 5'(count_reg), 1'b0, 32'd0};
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_KILL: begin
                if (link[QUEUE_DEPTH].gap) begin
                    cmd.op     = CELL_COMPACT;
                    count_next = count_reg - 1'b1;
                end else if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = 1'b0;
                    m_tlast_next  = 1'b1;
                    m_tdata_next  = {2'b00, 5'(count_reg), 1'b0, 32'd0};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        fire_cnt_reg <= fire_cnt_next;
        now_reg      <= now_next;
        owner_reg    <= owner_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
        m_tlast_reg  <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("event count exceeds queue depth");

    a_add_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == KIND_ADD) && (count_reg != CNT_W'(QUEUE_DEPTH)))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("accepted add did not grow the queue");

    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg > CNT_W'(1)) |-> (cell_entry[0].expiry <= cell_entry[1].expiry))
        else $error("queue head out of expiry order");

endmodule
